### design/sqp_pkg.sv
package sqp_pkg;

	// number of CORDIC micro-rotations
	localparam int CORDIC_N = 30;
	// square root digits (one result bit per cell, 61-bit radicand)
	localparam int SQRT_N = 31;
	// quotient bits, the top one flags overflow
	localparam int DIV_N = 16;
	// input register, products, dot, linear products
	localparam int FRONT_N = 4;
	// number of register stages from accept to output register
	localparam int LAT = FRONT_N + SQRT_N + CORDIC_N + 1 + CORDIC_N + 2 + DIV_N + 1;

	localparam logic [16:0] ONE_T = 17'd65536;
	localparam logic [15:0] ONE_Q14 = 16'd16384;
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
	localparam logic [14:0] THR_RESET = 15'd16376;

	// configuration register index
	localparam logic REG_THRESHOLD = 1'b0;

	// data handed down the chain next to each item
	typedef struct packed {
		logic              lin;
		logic [3:0][15:0]  lin_r;
		logic [3:0][15:0]  a;
		logic [3:0][16:0]  bn;
		logic [16:0]       t;
		logic [29:0]       d30;
		logic [30:0]       s30;
		logic [3:0]        sgn;
	} side_t;

	// one CORDIC lane
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} cord_t;

	// one divider lane
	typedef struct packed {
		logic [51:0] rem;
		logic [15:0] q;
	} dv_t;

	// arctangent of 2^-i in radians, Q.30
	function automatic logic signed [33:0] atan_of(input int i);
		logic signed [33:0] v;
		case (i)
			0: v = 34'sd843314857;
			1: v = 34'sd497837829;
			2: v = 34'sd263043837;
			3: v = 34'sd133525159;
			4: v = 34'sd67021687;
			5: v = 34'sd33543516;
			6: v = 34'sd16775851;
			7: v = 34'sd8388437;
			8: v = 34'sd4194283;
			9: v = 34'sd2097149;
			10: v = 34'sd1048576;
			11: v = 34'sd524288;
			12: v = 34'sd262144;
			13: v = 34'sd131072;
			14: v = 34'sd65536;
			15: v = 34'sd32768;
			16: v = 34'sd16384;
			17: v = 34'sd8192;
			18: v = 34'sd4096;
			19: v = 34'sd2048;
			20: v = 34'sd1024;
			21: v = 34'sd512;
			22: v = 34'sd256;
			23: v = 34'sd128;
			24: v = 34'sd64;
			25: v = 34'sd32;
			26: v = 34'sd16;
			27: v = 34'sd8;
			28: v = 34'sd4;
			29: v = 34'sd2;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

### design/quaternion_slerp_core.sv
// Fixed-point quaternion slerp. Each input word carries a, b (Q1.14) and
// blend (Q1.16); each output word carries the interpolated quaternion,
// saturated to +-1.0, and a flag in m_tuser that marks the linear path.
// The core is a fully pipelined row of cells: four front stages, 31 square
// root cells, 30 CORDIC vectoring cells, a scaling multiply, 30 dual CORDIC
// rotation cells, two product stages, 16 divider cells and an output
// register. One word is accepted every cycle while the output is not
// stalled; the whole pipe holds while the output word waits.
module quaternion_slerp_core (
	input  logic          clk,
	input  logic          arst_n,
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 each), blend (17), zero pad
	input  logic [151:0]  s_tdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	// r_x, r_y, r_z, r_w (16 each)
	output logic [63:0]   m_tdata,
	// used_linear
	output logic [0:0]    m_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int LAT = sqp_pkg::LAT;
	localparam int SN = sqp_pkg::SQRT_N;
	localparam int CN = sqp_pkg::CORDIC_N;
	localparam int DN = sqp_pkg::DIV_N;

	logic           en;
	logic [LAT-1:0] vld_q;
	logic [14:0]    thr_q;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == sqp_pkg::REG_THRESHOLD) ? {17'd0, thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sqp_pkg::THR_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == sqp_pkg::REG_THRESHOLD)) begin
			thr_q <= pwdata[14:0];
		end
	end

	// pipe advances unless the output word is stuck
	assign en = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: input register, blend clamped to one
	logic signed [15:0] a_s1 [4];
	logic signed [15:0] b_s1 [4];
	logic [16:0]        t_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				a_s1[k] <= s_tdata[16*k +: 16];
				b_s1[k] <= s_tdata[64 + 16*k +: 16];
			end
			t_s1 <= (s_tdata[144:128] > sqp_pkg::ONE_T) ? sqp_pkg::ONE_T : s_tdata[144:128];
		end
	end

	// stage 2: component products
	logic signed [31:0] p_s2 [4];
	logic signed [15:0] a_s2 [4];
	logic signed [15:0] b_s2 [4];
	logic [16:0]        t_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				p_s2[k] <= a_s1[k] * b_s1[k];
				a_s2[k] <= a_s1[k];
				b_s2[k] <= b_s1[k];
			end
			t_s2 <= t_s1;
		end
	end

	// stage 3: dot product, short-way flip, path choice
	logic signed [33:0] dot;
	logic               neg;
	logic [33:0]        dabs;
	logic signed [16:0] bn [4];

	always_comb begin
		logic signed [16:0] bx;
		dot = 34'(p_s2[0]) + 34'(p_s2[1]) + 34'(p_s2[2]) + 34'(p_s2[3]);
		neg = dot[33];
		dabs = neg ? 34'(-dot) : 34'(dot);
		for (int k = 0; k < 4; k++) begin
			bx = 17'(b_s2[k]);
			bn[k] = neg ? -bx : bx;
		end
	end

	logic signed [15:0] a_s3 [4];
	logic signed [16:0] bn_s3 [4];
	logic [16:0]        t_s3;
	logic [33:0]        dabs_s3;
	logic               lin_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				a_s3[k] <= a_s2[k];
				bn_s3[k] <= bn[k];
			end
			t_s3 <= t_s2;
			dabs_s3 <= dabs;
			lin_s3 <= (dabs > 34'({thr_q, 14'd0})) || (dabs >= 34'h1000_0000);
		end
	end

	// stage 4: linear blend products, radicand 1 - dot^2
	logic [16:0] omt_s3;
	logic [29:0] d30;
	logic [59:0] sq;

	assign omt_s3 = 17'(18'(sqp_pkg::ONE_T) - 18'(t_s3));
	assign d30 = {dabs_s3[27:0], 2'b00};
	assign sq = d30 * d30;

	logic signed [33:0] la_s4 [4];
	logic signed [34:0] lb_s4 [4];
	logic signed [15:0] a_s4 [4];
	logic signed [16:0] bn_s4 [4];
	logic [16:0]        t_s4;
	logic [29:0]        d30_s4;
	logic [60:0]        rem_s4;
	logic               lin_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				la_s4[k] <= $signed({1'b0, omt_s3}) * a_s3[k];
				lb_s4[k] <= $signed({1'b0, t_s3}) * bn_s3[k];
				a_s4[k] <= a_s3[k];
				bn_s4[k] <= bn_s3[k];
			end
			t_s4 <= t_s3;
			d30_s4 <= d30;
			rem_s4 <= 61'h1000_0000_0000_0000 - 61'(sq);
			lin_s4 <= lin_s3;
		end
	end

	// linear result, rounded half away from zero, then saturated
	sqp_pkg::side_t side_in;

	always_comb begin
		logic signed [35:0] n;
		logic [35:0]        mag;
		logic [19:0]        q;
		logic [15:0]        m;
		side_in = '0;
		side_in.lin = lin_s4;
		side_in.t = t_s4;
		side_in.d30 = d30_s4;
		for (int k = 0; k < 4; k++) begin
			n = 36'(la_s4[k]) + 36'(lb_s4[k]);
			mag = n[35] ? 36'(-n) : 36'(n);
			q = 20'((mag + 36'd32768) >> 16);
			m = (q > 20'(sqp_pkg::ONE_Q14)) ? sqp_pkg::ONE_Q14 : q[15:0];
			side_in.lin_r[k] = n[35] ? -m : m;
			side_in.a[k] = a_s4[k];
			side_in.bn[k] = bn_s4[k];
		end
	end

	// square root chain: s30 = floor(sqrt(2^60 - d30^2))
	logic [60:0]    sq_v [SN+1];
	logic [60:0]    sq_r [SN+1];
	sqp_pkg::side_t sq_side [SN+1];

	assign sq_v[0] = rem_s4;
	assign sq_r[0] = '0;
	assign sq_side[0] = side_in;

	for (genvar j = 0; j < SN; j++) begin : g_sqrt
		sqp_sqrt_cell #(.STEP(j)) u_cell (
			.clk    (clk),
			.en     (en),
			.v_i    (sq_v[j]),
			.r_i    (sq_r[j]),
			.side_i (sq_side[j]),
			.v_o    (sq_v[j+1]),
			.r_o    (sq_r[j+1]),
			.side_o (sq_side[j+1])
		);
	end

	// vectoring chain: th = atan2(s30, d30)
	sqp_pkg::cord_t [0:0] vc [CN+1];
	sqp_pkg::side_t       vc_side [CN+1];

	always_comb begin
		vc_side[0] = sq_side[SN];
		vc_side[0].s30 = sq_r[SN][30:0];
		vc[0][0].x = 34'(sq_side[SN].d30);
		vc[0][0].y = 34'(sq_r[SN][30:0]);
		vc[0][0].z = '0;
	end

	for (genvar i = 0; i < CN; i++) begin : g_vect
		sqp_cordic_cell #(.STEP(i), .LANES(1), .VECT(1'b1)) u_cell (
			.clk    (clk),
			.en     (en),
			.c_i    (vc[i]),
			.side_i (vc_side[i]),
			.c_o    (vc[i+1]),
			.side_o (vc_side[i+1])
		);
	end

	// scale the angle by 1-t and by t
	logic signed [33:0] th;
	logic [16:0]        omt_v;
	logic signed [51:0] ph1, ph2;

	assign th = vc[CN][0].z;
	assign omt_v = 17'(18'(sqp_pkg::ONE_T) - 18'(vc_side[CN].t));
	assign ph1 = th * $signed({1'b0, omt_v});
	assign ph2 = th * $signed({1'b0, vc_side[CN].t});

	logic signed [33:0] th1_s66, th2_s66;
	sqp_pkg::side_t     side_s66;

	always_ff @(posedge clk) begin
		if (en) begin
			th1_s66 <= 34'(ph1 >>> 16);
			th2_s66 <= 34'(ph2 >>> 16);
			side_s66 <= vc_side[CN];
		end
	end

	// rotation chain, two lanes: sin(th1), sin(th2)
	sqp_pkg::cord_t [1:0] rc [CN+1];
	sqp_pkg::side_t       rc_side [CN+1];

	always_comb begin
		rc[0][0].x = sqp_pkg::CORDIC_GAIN_INV;
		rc[0][0].y = '0;
		rc[0][0].z = th1_s66;
		rc[0][1].x = sqp_pkg::CORDIC_GAIN_INV;
		rc[0][1].y = '0;
		rc[0][1].z = th2_s66;
		rc_side[0] = side_s66;
	end

	for (genvar i = 0; i < CN; i++) begin : g_rot
		sqp_cordic_cell #(.STEP(i), .LANES(2), .VECT(1'b0)) u_cell (
			.clk    (clk),
			.en     (en),
			.c_i    (rc[i]),
			.side_i (rc_side[i]),
			.c_o    (rc[i+1]),
			.side_o (rc_side[i+1])
		);
	end

	// weighted products
	logic signed [51:0] pa_s97 [4];
	logic signed [51:0] pb_s97 [4];
	sqp_pkg::side_t     side_s97;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pa_s97[k] <= rc[CN][0].y * $signed(rc_side[CN].a[k]);
				pb_s97[k] <= rc[CN][1].y * $signed(rc_side[CN].bn[k]);
			end
			side_s97 <= rc_side[CN];
		end
	end

	// numerator magnitude plus half the divisor
	sqp_pkg::dv_t [3:0] dnum;
	sqp_pkg::side_t     dside;

	always_comb begin
		logic signed [51:0] n;
		logic [51:0]        mag;
		dside = side_s97;
		for (int k = 0; k < 4; k++) begin
			n = pa_s97[k] + pb_s97[k];
			mag = n[51] ? 52'(-n) : 52'(n);
			dnum[k].rem = mag + 52'(side_s97.s30 >> 1);
			dnum[k].q = '0;
			dside.sgn[k] = n[51];
		end
	end

	sqp_pkg::dv_t [3:0] dc [DN+1];
	sqp_pkg::side_t     dc_side [DN+1];

	always_ff @(posedge clk) begin
		if (en) begin
			dc[0] <= dnum;
			dc_side[0] <= dside;
		end
	end

	// divider chain, most significant quotient bit first
	for (genvar c = 0; c < DN; c++) begin : g_div
		sqp_div_cell #(.STEP(DN - 1 - c)) u_cell (
			.clk    (clk),
			.en     (en),
			.d_i    (dc[c]),
			.side_i (dc_side[c]),
			.d_o    (dc[c+1]),
			.side_o (dc_side[c+1])
		);
	end

	// saturate, apply sign, choose path
	logic [63:0] res;

	always_comb begin
		logic [15:0] q;
		logic [15:0] m;
		sqp_pkg::side_t sd;
		sd = dc_side[DN];
		for (int k = 0; k < 4; k++) begin
			q = dc[DN][k].q;
			m = (q[15] || (q > sqp_pkg::ONE_Q14)) ? sqp_pkg::ONE_Q14 : q;
			res[16*k +: 16] = sd.lin ? sd.lin_r[k] : (sd.sgn[k] ? -m : m);
		end
	end

	logic [63:0] data_s115;
	logic        lin_s115;

	always_ff @(posedge clk) begin
		if (en) begin
			data_s115 <= res;
			lin_s115 <= dc_side[DN].lin;
		end
	end

	assign m_tdata = data_s115;
	assign m_tuser = lin_s115;

endmodule

### design/sqp_sqrt_cell.sv
// one digit of the restoring integer square root
module sqp_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic [60:0]     v_i,
	input  logic [60:0]     r_i,
	input  sqp_pkg::side_t  side_i,
	output logic [60:0]     v_o,
	output logic [60:0]     r_o,
	output sqp_pkg::side_t  side_o
);

	localparam logic [60:0] BIT = 61'(1) << (60 - 2 * STEP);

	logic [60:0] trial;
	logic        take;
	logic [60:0] v_s1, r_s1;
	sqp_pkg::side_t side_s1;

	// trial subtract of r + bit
	always_comb begin
		trial = r_i + BIT;
		take = v_i >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= take ? v_i - trial : v_i;
			r_s1 <= take ? (r_i >> 1) + BIT : r_i >> 1;
			side_s1 <= side_i;
		end
	end

	assign v_o = v_s1;
	assign r_o = r_s1;
	assign side_o = side_s1;

endmodule

### design/sqp_cordic_cell.sv
// one CORDIC micro-rotation, vectoring or rotation mode, over LANES lanes
module sqp_cordic_cell #(
	parameter int STEP = 0,
	parameter int LANES = 1,
	parameter bit VECT = 1'b1
) (
	input  logic                         clk,
	input  logic                         en,
	input  sqp_pkg::cord_t [LANES-1:0]   c_i,
	input  sqp_pkg::side_t               side_i,
	output sqp_pkg::cord_t [LANES-1:0]   c_o,
	output sqp_pkg::side_t               side_o
);

	localparam logic signed [33:0] ATAN = sqp_pkg::atan_of(STEP);

	sqp_pkg::cord_t [LANES-1:0] nxt;
	sqp_pkg::cord_t [LANES-1:0] c_s1;
	sqp_pkg::side_t side_s1;

	// direction from y in vectoring mode, from z in rotation mode
	always_comb begin
		logic signed [33:0] dx, dy;
		logic               s;
		for (int l = 0; l < LANES; l++) begin
			dx = $signed(c_i[l].y) >>> STEP;
			dy = $signed(c_i[l].x) >>> STEP;
			s = VECT ? !c_i[l].y[33] : c_i[l].z[33];
			if (s) begin
				nxt[l].x = c_i[l].x + dx;
				nxt[l].y = c_i[l].y - dy;
				nxt[l].z = c_i[l].z + ATAN;
			end else begin
				nxt[l].x = c_i[l].x - dx;
				nxt[l].y = c_i[l].y + dy;
				nxt[l].z = c_i[l].z - ATAN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= nxt;
			side_s1 <= side_i;
		end
	end

	assign c_o = c_s1;
	assign side_o = side_s1;

endmodule

### design/sqp_div_cell.sv
// one quotient bit of a restoring divide, four lanes sharing the divisor
module sqp_div_cell #(
	parameter int STEP = 0
) (
	input  logic                    clk,
	input  logic                    en,
	input  sqp_pkg::dv_t [3:0]      d_i,
	input  sqp_pkg::side_t          side_i,
	output sqp_pkg::dv_t [3:0]      d_o,
	output sqp_pkg::side_t          side_o
);

	logic [51:0] dsh;
	sqp_pkg::dv_t [3:0] nxt;
	sqp_pkg::dv_t [3:0] d_s1;
	sqp_pkg::side_t side_s1;

	// divisor is sin(th) carried with the item
	always_comb begin
		dsh = 52'(side_i.s30) << STEP;
		for (int l = 0; l < 4; l++) begin
			nxt[l] = d_i[l];
			if (d_i[l].rem >= dsh) begin
				nxt[l].rem = d_i[l].rem - dsh;
				nxt[l].q[STEP] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
			side_s1 <= side_i;
		end
	end

	assign d_o = d_s1;
	assign side_o = side_s1;

endmodule

### design/sqp_checker.sv
module sqp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tready,
	input logic [63:0]   m_tdata,
	input logic [0:0]    m_tuser,
	input logic          m_tvalid,
	input logic          m_tready
);

	// a stalled output word stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// the pipe holds while the output waits
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// every component stays within +-1.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) >= -16384) && ($signed(m_tdata[15:0]) <= 16384)
			&& ($signed(m_tdata[31:16]) >= -16384) && ($signed(m_tdata[31:16]) <= 16384)
			&& ($signed(m_tdata[47:32]) >= -16384) && ($signed(m_tdata[47:32]) <= 16384)
			&& ($signed(m_tdata[63:48]) >= -16384) && ($signed(m_tdata[63:48]) <= 16384))
		else $error("component out of range");

endmodule

bind quaternion_slerp_core sqp_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
